>>> sv/int_to_decimal_ascii_core_defines.svh
// Assertion macros for the checker module.
`ifndef INT_TO_DECIMAL_ASCII_CORE_DEFINES_SVH
`define INT_TO_DECIMAL_ASCII_CORE_DEFINES_SVH

// Assert a property on a given clock, disabled while the given reset is low.
`define I2D_ASSERT_CLK(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// Assert a property on the block clock and reset.
`define I2D_ASSERT(lbl, prop, msg) `I2D_ASSERT_CLK(lbl, clk_i, rst_ni, prop, msg)

`endif

>>> sv/i2d_pkg.sv
`default_nettype none

package i2d_pkg;

  localparam int DefValueBits = 32;
  localparam int QueueDepth   = 2;

  localparam logic [7:0] CHAR_ZERO  = 8'd48;
  localparam logic [7:0] CHAR_MINUS = 8'd45;

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_SIGN,
    BK_DIGIT
  } back_state_e;

  // Powers of ten up to the largest that a 64-bit magnitude can need.
  function automatic logic [63:0] pow10(input logic [4:0] k);
    logic [63:0] p;
    unique case (k)
      5'd0:  p = 64'd1;
      5'd1:  p = 64'd10;
      5'd2:  p = 64'd100;
      5'd3:  p = 64'd1000;
      5'd4:  p = 64'd10000;
      5'd5:  p = 64'd100000;
      5'd6:  p = 64'd1000000;
      5'd7:  p = 64'd10000000;
      5'd8:  p = 64'd100000000;
      5'd9:  p = 64'd1000000000;
      5'd10: p = 64'd10000000000;
      5'd11: p = 64'd100000000000;
      5'd12: p = 64'd1000000000000;
      5'd13: p = 64'd10000000000000;
      5'd14: p = 64'd100000000000000;
      5'd15: p = 64'd1000000000000000;
      5'd16: p = 64'd10000000000000000;
      5'd17: p = 64'd100000000000000000;
      5'd18: p = 64'd1000000000000000000;
      5'd19: p = 64'd10000000000000000000;
      default: p = 64'd0;
    endcase
    return p;
  endfunction

endpackage

`default_nettype wire

>>> sv/int_to_decimal_ascii_core.sv
// Signed integer to decimal ASCII. Each accepted word is a two's-complement
// value; the block returns its decimal text one character per output word:
// '-' first for a negative value, then the digits most significant first with
// no leading zeros ("0" for zero), last set on the final digit. The front end
// pushes each accepted word into a two-entry queue; the back end unloads it,
// sends the sign when the value is negative, then walks the decimal positions
// (10 positions at 32 bits) from the top. The digit sequencer resolves one
// decimal position per cycle against a table of powers of ten while the output
// is not stalled; leading zeros advance even when it is. Output back-pressure
// stalls the back end and reaches the input once the queue is full.
`default_nettype none

module int_to_decimal_ascii_core import i2d_pkg::*; #(
  parameter int VALUE_BITS = DefValueBits
) (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         in_valid_i,
  output      logic                         in_ready_o,
  input  wire logic signed [VALUE_BITS-1:0] value_i,
  output      logic                         out_valid_o,
  input  wire logic                         out_ready_i,
  output      logic        [7:0]            char_code_o,
  output      logic                         last_o
);

  logic                  q_full;
  logic                  q_push;
  logic                  q_neg_w;
  logic [VALUE_BITS-1:0] q_mag_w;
  logic                  q_nempty;
  logic                  q_pop;
  logic [VALUE_BITS:0]   q_rdata;

  i2d_front #(
    .VALUE_BITS(VALUE_BITS)
  ) u_front (
    .in_valid_i(in_valid_i),
    .in_ready_o(in_ready_o),
    .value_i   (value_i),
    .q_full_i  (q_full),
    .q_push_o  (q_push),
    .q_neg_o   (q_neg_w),
    .q_mag_o   (q_mag_w)
  );

  i2d_fifo #(
    .WIDTH(VALUE_BITS + 1),
    .DEPTH(QueueDepth)
  ) u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .wdata_i ({q_neg_w, q_mag_w}),
    .full_o  (q_full),
    .pop_i   (q_pop),
    .nempty_o(q_nempty),
    .rdata_o (q_rdata)
  );

  i2d_back #(
    .VALUE_BITS(VALUE_BITS)
  ) u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .q_nempty_i (q_nempty),
    .q_pop_o    (q_pop),
    .q_neg_i    (q_rdata[VALUE_BITS]),
    .q_mag_i    (q_rdata[VALUE_BITS-1:0]),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .char_code_o(char_code_o),
    .last_o     (last_o)
  );

endmodule

`default_nettype wire

>>> sv/i2d_front.sv
`default_nettype none

module i2d_front import i2d_pkg::*; #(
  parameter int VALUE_BITS = DefValueBits
) (
  input  wire logic                         in_valid_i,
  output      logic                         in_ready_o,
  input  wire logic signed [VALUE_BITS-1:0] value_i,
  input  wire logic                         q_full_i,
  output      logic                         q_push_o,
  output      logic                         q_neg_o,
  output      logic        [VALUE_BITS-1:0] q_mag_o
);

  logic [VALUE_BITS-1:0] raw;

  assign raw        = value_i;
  assign in_ready_o = !q_full_i;
  assign q_push_o   = in_valid_i && !q_full_i;
  assign q_neg_o    = raw[VALUE_BITS-1];
  // Magnitude modulo 2^VALUE_BITS, so the most negative value comes out right.
  assign q_mag_o    = q_neg_o ? (~raw + VALUE_BITS'(1)) : raw;

endmodule

`default_nettype wire

>>> sv/i2d_fifo.sv
`default_nettype none

module i2d_fifo import i2d_pkg::*; #(
  parameter int WIDTH = DefValueBits + 1,
  parameter int DEPTH = QueueDepth
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             push_i,
  input  wire logic [WIDTH-1:0] wdata_i,
  output      logic             full_o,
  input  wire logic             pop_i,
  output      logic             nempty_o,
  output      logic [WIDTH-1:0] rdata_o
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [AW-1:0]    wptr_q, wptr_d;
  logic [AW-1:0]    rptr_q, rptr_d;
  logic [AW:0]      cnt_q, cnt_d;
  logic             do_push, do_pop;

  assign full_o   = (cnt_q == (AW+1)'(DEPTH));
  assign nempty_o = (cnt_q != '0);
  assign rdata_o  = mem_q[rptr_q];
  assign do_push  = push_i && !full_o;
  assign do_pop   = pop_i && nempty_o;

  always_comb begin
    wptr_d = wptr_q;
    rptr_d = rptr_q;
    cnt_d  = cnt_q;
    if (do_push) begin
      wptr_d = (wptr_q == AW'(DEPTH-1)) ? '0 : wptr_q + AW'(1);
    end
    if (do_pop) begin
      rptr_d = (rptr_q == AW'(DEPTH-1)) ? '0 : rptr_q + AW'(1);
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + (AW+1)'(1);
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - (AW+1)'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      wptr_q <= wptr_d;
      rptr_q <= rptr_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wptr_q] <= wdata_i;
    end
  end

endmodule

`default_nettype wire

>>> sv/i2d_back.sv
`default_nettype none

module i2d_back import i2d_pkg::*; #(
  parameter int VALUE_BITS = DefValueBits
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  q_nempty_i,
  output      logic                  q_pop_o,
  input  wire logic                  q_neg_i,
  input  wire logic [VALUE_BITS-1:0] q_mag_i,
  output      logic                  out_valid_o,
  input  wire logic                  out_ready_i,
  output      logic [7:0]            char_code_o,
  output      logic                  last_o
);

  // Decimal positions needed: floor(VALUE_BITS * log10(2)) + 1.
  localparam int DIGITS = (VALUE_BITS * 1233) / 4096 + 1;
  localparam int KW     = $clog2(DIGITS);
  localparam int MW     = VALUE_BITS + 4;
  localparam logic [KW-1:0] TOP = KW'(DIGITS - 1);

  back_state_e           state_q, state_d;
  logic [VALUE_BITS-1:0] mag_q, mag_d;
  logic [KW-1:0]         k_q, k_d, k_sel;
  logic                  started_q, started_d;
  logic [MW-1:0]         mul_q [9];
  logic [MW-1:0]         mul_d [9];
  logic                  mul_en;
  logic [MW-1:0]         pw;
  logic [MW-1:0]         mag_ext;
  logic [3:0]            digit;
  logic [MW-1:0]         sub;
  logic                  show;
  logic                  can_emit;
  logic                  emit;
  logic [7:0]            emit_char;
  logic                  emit_last;
  logic                  out_valid_q, out_valid_d;
  logic [7:0]            char_q;
  logic                  last_q;

  assign can_emit = !out_valid_q || out_ready_i;
  assign mag_ext  = MW'(mag_q);

  // Multiples 1..9 of the power of ten for the next position.
  assign k_sel = (state_q == BK_IDLE) ? TOP : k_q - KW'(1);
  assign pw    = MW'(pow10(5'(k_sel)));

  always_comb begin
    for (int j = 0; j < 9; j++) begin
      mul_d[j] = pw * MW'(j + 1);
    end
  end

  // Digit at this position: how many of the multiples still fit.
  always_comb begin
    digit = '0;
    sub   = '0;
    for (int j = 0; j < 9; j++) begin
      if (mag_ext >= mul_q[j]) begin
        digit = 4'(j + 1);
        sub   = mul_q[j];
      end
    end
  end

  assign show = (digit != '0) || started_q || (k_q == '0);

  always_comb begin
    state_d   = state_q;
    mag_d     = mag_q;
    k_d       = k_q;
    started_d = started_q;
    mul_en    = 1'b0;
    q_pop_o   = 1'b0;
    emit      = 1'b0;
    emit_char = CHAR_ZERO + {4'b0, digit};
    emit_last = 1'b0;
    unique case (state_q)
      BK_IDLE: begin
        if (q_nempty_i) begin
          q_pop_o   = 1'b1;
          mag_d     = q_mag_i;
          k_d       = TOP;
          started_d = 1'b0;
          mul_en    = 1'b1;
          state_d   = q_neg_i ? BK_SIGN : BK_DIGIT;
        end
      end
      BK_SIGN: begin
        if (can_emit) begin
          emit      = 1'b1;
          emit_char = CHAR_MINUS;
          state_d   = BK_DIGIT;
        end
      end
      BK_DIGIT: begin
        // Leading zeros advance without waiting on the output.
        if (!show || can_emit) begin
          emit      = show;
          emit_last = (k_q == '0);
          mag_d     = mag_q - VALUE_BITS'(sub);
          started_d = started_q || show;
          if (k_q == '0) begin
            state_d = BK_IDLE;
          end else begin
            k_d    = k_q - KW'(1);
            mul_en = 1'b1;
          end
        end
      end
      default: state_d = BK_IDLE;
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (emit) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= BK_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    mag_q     <= mag_d;
    k_q       <= k_d;
    started_q <= started_d;
    if (mul_en) begin
      mul_q <= mul_d;
    end
    if (emit) begin
      char_q <= emit_char;
      last_q <= emit_last;
    end
  end

  assign out_valid_o = out_valid_q;
  assign char_code_o = char_q;
  assign last_o      = last_q;

endmodule

`default_nettype wire

>>> sv/i2d_sva.sv
`default_nettype none
`include "int_to_decimal_ascii_core_defines.svh"

module i2d_sva import i2d_pkg::*; (
  input wire logic       clk_i,
  input wire logic       rst_ni,
  input wire logic       out_valid_o,
  input wire logic       out_ready_i,
  input wire logic [7:0] char_code_o,
  input wire logic       last_o
);

  `I2D_ASSERT(a_out_hold, out_valid_o && !out_ready_i |=> out_valid_o && $stable(char_code_o) && $stable(last_o), "output word changed while stalled")

  `I2D_ASSERT(a_char_set, out_valid_o |-> (char_code_o == CHAR_MINUS) || ((char_code_o >= CHAR_ZERO) && (char_code_o <= CHAR_ZERO + 8'd9)), "character outside sign and digits")

  `I2D_ASSERT(a_sign_not_last, out_valid_o && (char_code_o == CHAR_MINUS) |-> !last_o, "sign marked as last character")

  `I2D_ASSERT(a_no_zero_after_sign, out_valid_o && out_ready_i && (char_code_o == CHAR_MINUS) |=> !(out_valid_o && (char_code_o == CHAR_ZERO)), "leading zero after sign")

endmodule

bind int_to_decimal_ascii_core i2d_sva u_i2d_sva (
  .clk_i      (clk_i),
  .rst_ni     (rst_ni),
  .out_valid_o(out_valid_o),
  .out_ready_i(out_ready_i),
  .char_code_o(char_code_o),
  .last_o     (last_o)
);

`default_nettype wire

>>> tb/int_to_decimal_ascii_core_test.sv
`default_nettype none

module int_to_decimal_ascii_core_test;
  import i2d_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int ValueBits = DefValueBits;

  typedef struct packed {
    logic [7:0] code;
    logic       is_last;
  } char_word_t;

  logic                        clk_i = 1'b0;
  logic                        rst_ni = 1'b0;
  logic                        in_valid_i = 1'b0;
  logic                        in_ready_o;
  logic signed [ValueBits-1:0] value_i = '0;
  logic                        out_valid_o;
  logic                        out_ready_i = 1'b0;
  logic [7:0]                  char_code_o;
  logic                        last_o;

  char_word_t pending_chars[$];
  int         fail_count = 0;
  bit         idle_on = 1'b1;

  int_to_decimal_ascii_core #(
    .VALUE_BITS(ValueBits)
  ) DUT (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .value_i    (value_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .char_code_o(char_code_o),
    .last_o     (last_o)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    #5ms;
    $display("** int_to_decimal_ascii_core: FAILED **");
    $finish;
  end

  // Expected decimal text of one value, one entry per character.
  function automatic void predict_text(input logic [ValueBits-1:0] raw);
    logic [ValueBits-1:0] mag;
    logic [3:0]           digs[20];
    int                   n;
    mag = raw[ValueBits-1] ? (~raw + 1'b1) : raw;
    n = 0;
    do begin
      digs[n] = 4'(mag % 10);
      n++;
      mag = mag / 10;
    end while (mag != 0);
    if (raw[ValueBits-1]) begin
      pending_chars.push_back('{code: CHAR_MINUS, is_last: 1'b0});
    end
    for (int k = n - 1; k >= 0; k--) begin
      pending_chars.push_back('{code: CHAR_ZERO + 8'(digs[k]), is_last: (k == 0)});
    end
  endfunction

  // Send one word; valid stays high from the previous word when there is no gap.
  task automatic send_value(input logic [ValueBits-1:0] v);
    int gap;
    gap = (idle_on && $urandom_range(0, 3) == 0) ? $urandom_range(1, 12) : 0;
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      value_i    <= $urandom;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    value_i    <= v;
    do @(posedge clk_i); while (!in_ready_o);
    predict_text(v);
  endtask

  // Hold the sender until every character has come back.
  task automatic wait_for_text();
    in_valid_i <= 1'b0;
    value_i    <= $urandom;
    while (pending_chars.size() != 0) @(posedge clk_i);
  endtask

  function automatic logic [ValueBits-1:0] random_value();
    logic [ValueBits-1:0] v;
    case ($urandom_range(0, 2))
      0: v = $urandom;
      1: begin
        // spread the digit count evenly-ish, either sign
        v = $urandom >> $urandom_range(1, 31);
        if ($urandom_range(0, 1)) v = -v;
      end
      default: v = $urandom_range(0, 1) ? $urandom_range(0, 20) : -$urandom_range(0, 20);
    endcase
    return v;
  endfunction

  task automatic test_directed_extremes();
    logic [ValueBits-1:0] vals[$];
    vals = '{32'sd0, 32'sd1, -32'sd1, 32'sd9, 32'sd10, -32'sd10, 32'sd99, 32'sd100,
             -32'sd100, 32'sd999999999, 32'sd1000000000, -32'sd999999999,
             -32'sd1000000000, 32'sd1234567890, -32'sd1234567890,
             32'sh7fffffff, 32'sh80000000, 32'sh80000001, 32'sh55555555,
             32'shaaaaaaaa, 32'sd2000000000, -32'sd2147483647};
    foreach (vals[i]) send_value(vals[i]);
  endtask

  task automatic test_random_values(input int count);
    for (int i = 0; i < count; i++) begin
      send_value(random_value());
      // pause now and then with a full drain
      if ($urandom_range(0, 29) == 0) wait_for_text();
    end
  endtask

  task automatic test_back_to_back(input int count);
    idle_on = 1'b0;
    for (int i = 0; i < count; i++) send_value(random_value());
  endtask

  // Receiver: stall in bursts and compare each character taken.
  initial begin
    int         stall_left;
    char_word_t exp_word;
    stall_left = 0;
    forever begin
      @(posedge clk_i);
      if (rst_ni && out_valid_o && out_ready_i) begin
        if (pending_chars.size() == 0) begin
          fail_count++;
          if (fail_count <= 10) begin
            $display("unexpected character: code %0d last %0b", char_code_o, last_o);
          end
        end else begin
          exp_word = pending_chars.pop_front();
          if (char_code_o !== exp_word.code || last_o !== exp_word.is_last) begin
            fail_count++;
            if (fail_count <= 10) begin
              $display("character mismatch: expected code %0d last %0b, got code %0d last %0b",
                       exp_word.code, exp_word.is_last, char_code_o, last_o);
            end
          end
        end
      end
      if (stall_left > 0) begin
        stall_left--;
        out_ready_i <= 1'b0;
      end else if (idle_on && $urandom_range(0, 7) == 0) begin
        stall_left  = $urandom_range(1, 12) - 1;
        out_ready_i <= 1'b0;
      end else begin
        out_ready_i <= 1'b1;
      end
    end
  end

  initial begin
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed_extremes();
    wait_for_text();
    test_random_values(140);
    wait_for_text();
    test_back_to_back(60);
    wait_for_text();
    // let any stray characters surface
    repeat (40) @(posedge clk_i);
    if (fail_count == 0 && pending_chars.size() == 0) begin
      $display("** int_to_decimal_ascii_core: PASSED **");
    end else begin
      $display("** int_to_decimal_ascii_core: FAILED **");
    end
    $finish;
  end

endmodule

`default_nettype wire
